@@ rtl/gbe_pkg.sv @@
// Shared constants and types for the glyph bitmap expander.
`timescale 1ns / 1ps

package gbe_pkg;

  localparam int WORD_BITS = 16;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [15:0]          color_t;
  typedef logic [9:0]           coord_t;
  typedef logic [7:0]           count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR     = 3'd0,
    CFG_BG_COLOR     = 3'd1,
    CFG_GLYPH_WIDTH  = 3'd2,
    CFG_GLYPH_HEIGHT = 3'd3,
    CFG_ORIGIN_X     = 3'd4,
    CFG_ORIGIN_Y     = 3'd5,
    CFG_PANEL_WIDTH  = 3'd6,
    CFG_PANEL_HEIGHT = 3'd7
  } cfg_reg_t;

endpackage

@@ rtl/gbe_in_if.sv @@
// Bitmap word channel: valid/ready handshake with word payload.
`timescale 1ns / 1ps

interface gbe_in_if;
  logic            valid;
  logic            ready;
  gbe_pkg::word_t  bitmap_word;
  logic            start_glyph;

  modport source (output valid, output bitmap_word, output start_glyph, input ready);
  modport sink   (input valid, input bitmap_word, input start_glyph, output ready);
endinterface

@@ rtl/gbe_out_if.sv @@
// Pixel channel: valid/ready handshake with pixel payload.
`timescale 1ns / 1ps

interface gbe_out_if;
  logic             valid;
  logic             ready;
  gbe_pkg::color_t  pixel_color;
  gbe_pkg::coord_t  pixel_column;
  gbe_pkg::coord_t  pixel_row;
  logic             glyph_done;
  logic             last;

  modport source (output valid, output pixel_color, output pixel_column, output pixel_row,
                  output glyph_done, output last, input ready);
  modport sink   (input valid, input pixel_color, input pixel_column, input pixel_row,
                  input glyph_done, input last, output ready);
endinterface

@@ rtl/glyph_bitmap_expander_core.sv @@
// Glyph bitmap expander: 1bpp glyph words to RGB565 pixel transactions.
// The first pixel of a word passes through mask_r and then through the output register.
// Throughput: one pixel per cycle while the sink is ready; the next word is accepted as
// the last pixel of the current one is loaded, and a word that yields none leaves the mask empty.
// The pixel walk over the word's emit mask sets how many pixels a word yields (0 to 16).
// Reset (rst_n low, synchronous): position, mask and output valid cleared, configuration registers to defaults.
`timescale 1ns / 1ps

module glyph_bitmap_expander_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  gbe_in_if.sink                               in_ch,
  gbe_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [gbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbe_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration registers
  gbe_pkg::color_t fg_color_r;
  logic [16:0]     bg_color_r;
  gbe_pkg::count_t glyph_width_r;
  gbe_pkg::count_t glyph_height_r;
  gbe_pkg::coord_t origin_x_r;
  gbe_pkg::coord_t origin_y_r;
  gbe_pkg::coord_t panel_width_r;
  gbe_pkg::coord_t panel_height_r;

  // glyph position
  gbe_pkg::count_t col_r, col_nxt;
  gbe_pkg::count_t row_r, row_nxt;

  // word being expanded
  gbe_pkg::word_t  mask_r, mask_nxt;
  gbe_pkg::word_t  bits_r;
  gbe_pkg::coord_t base_col_r;
  gbe_pkg::coord_t pix_row_r;
  logic            done_r;

  // output register
  logic            out_valid_r;
  gbe_pkg::color_t out_color_r;
  gbe_pkg::coord_t out_col_r;
  gbe_pkg::coord_t out_row_r;
  logic            out_done_r;
  logic            out_last_r;

  logic            in_fire;
  logic            out_load;
  gbe_pkg::word_t  lowbit;
  gbe_pkg::word_t  rest;
  gbe_pkg::idx_t   low_idx;

  // accept-side decode
  logic            zero_size;
  gbe_pkg::count_t cc, rc;
  gbe_pkg::count_t span;
  logic            n_full;
  gbe_pkg::count_t cnt;
  logic [8:0]      cc_sum;
  logic [8:0]      rc_inc;
  logic            fits;
  logic            done_w;
  logic            transparent;
  gbe_pkg::word_t  rev;
  gbe_pkg::word_t  pos_mask;
  gbe_pkg::word_t  emit_mask;

  always_comb begin
    zero_size = (glyph_width_r == '0) || (glyph_height_r == '0);
    if (in_ch.start_glyph || (col_r >= glyph_width_r) || (row_r >= glyph_height_r)) begin
      cc = '0;
      rc = '0;
    end else begin
      cc = col_r;
      rc = row_r;
    end
    span   = glyph_width_r - cc;
    n_full = (span >= 8'(gbe_pkg::WORD_BITS));
    cnt    = n_full ? 8'(gbe_pkg::WORD_BITS) : span;
    cc_sum = {1'b0, cc} + {1'b0, cnt};
    rc_inc = {1'b0, rc} + 9'd1;
    fits   = ({1'b0, origin_x_r} + {3'b0, glyph_width_r} <= {1'b0, panel_width_r}) &&
             ({1'b0, origin_y_r} + {3'b0, glyph_height_r} <= {1'b0, panel_height_r});
    done_w = (cc_sum == {1'b0, glyph_width_r}) && (rc_inc == {1'b0, glyph_height_r});
    transparent = bg_color_r[16];
    for (int i = 0; i < gbe_pkg::WORD_BITS; i++) begin
      rev[i]      = in_ch.bitmap_word[gbe_pkg::WORD_BITS-1-i];
      pos_mask[i] = n_full || (8'(i) < span);
    end
    emit_mask = (fits && !zero_size) ? (pos_mask & (transparent ? rev : '1)) : '0;

    // advance position
    if (zero_size) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cc_sum >= {1'b0, glyph_width_r}) begin
      col_nxt = '0;
      row_nxt = (rc_inc >= {1'b0, glyph_height_r}) ? '0 : rc_inc[7:0];
    end else begin
      col_nxt = cc_sum[7:0];
      row_nxt = rc;
    end
  end

  // pixel walk: lowest pending position goes out next
  always_comb begin
    lowbit  = mask_r & (~mask_r + gbe_pkg::word_t'(1));
    rest    = mask_r & ~lowbit;
    low_idx = '0;
    for (int i = gbe_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (mask_r[i]) low_idx = gbe_pkg::idx_t'(i);
    end
    out_load    = (mask_r != '0) && (!out_valid_r || out_ch.ready);
    in_ch.ready = out_load ? (rest == '0) : (mask_r == '0);
    in_fire     = in_ch.valid && in_ch.ready;
    if (in_fire) begin
      mask_nxt = emit_mask;
    end else if (out_load) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r     <= 16'hFFFF;
      bg_color_r     <= '0;
      glyph_width_r  <= 8'd8;
      glyph_height_r <= 8'd16;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      panel_width_r  <= 10'd240;
      panel_height_r <= 10'd135;
    end else if (cfg_we) begin
      case (gbe_pkg::cfg_reg_t'(cfg_index))
        gbe_pkg::CFG_FG_COLOR:     fg_color_r     <= cfg_data[15:0];
        gbe_pkg::CFG_BG_COLOR:     bg_color_r     <= cfg_data[16:0];
        gbe_pkg::CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[7:0];
        gbe_pkg::CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[7:0];
        gbe_pkg::CFG_ORIGIN_X:     origin_x_r     <= cfg_data[9:0];
        gbe_pkg::CFG_ORIGIN_Y:     origin_y_r     <= cfg_data[9:0];
        gbe_pkg::CFG_PANEL_WIDTH:  panel_width_r  <= cfg_data[9:0];
        gbe_pkg::CFG_PANEL_HEIGHT: panel_height_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bits_r     <= rev;
      base_col_r <= origin_x_r + {2'b0, cc};
      pix_row_r  <= origin_y_r + {2'b0, rc};
      done_r     <= done_w;
    end
    if (out_load) begin
      out_color_r <= bits_r[low_idx] ? fg_color_r : bg_color_r[15:0];
      out_col_r   <= base_col_r + 10'(low_idx);
      out_row_r   <= pix_row_r;
      out_last_r  <= (rest == '0);
      out_done_r  <= (rest == '0) && done_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_color  = out_color_r;
  assign out_ch.pixel_column = out_col_r;
  assign out_ch.pixel_row    = out_row_r;
  assign out_ch.glyph_done   = out_done_r;
  assign out_ch.last         = out_last_r;

endmodule

@@ sim/tb_top.sv @@
// Testbench for glyph_bitmap_expander_core: directed and random glyph streams, checked per pixel.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 340;

  typedef struct packed {
    gbe_pkg::word_t bits;
    logic           first;
  } word_item_t;

  typedef struct packed {
    gbe_pkg::color_t color;
    gbe_pkg::coord_t col;
    gbe_pkg::coord_t row;
    logic            done;
    logic            last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [gbe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gbe_pkg::CFG_DATA_W-1:0] cfg_data;

  gbe_in_if  word_if ();
  gbe_out_if pixel_if ();

  glyph_bitmap_expander_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (word_if),
    .out_ch    (pixel_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the register file and the glyph position
  gbe_pkg::color_t cur_fg     = 16'hFFFF;
  logic [16:0]     cur_bg     = 17'h00000;
  gbe_pkg::count_t cur_width  = 8'd8;
  gbe_pkg::count_t cur_height = 8'd16;
  gbe_pkg::coord_t cur_ox     = 10'd0;
  gbe_pkg::coord_t cur_oy     = 10'd0;
  gbe_pkg::coord_t cur_pw     = 10'd240;
  gbe_pkg::coord_t cur_ph     = 10'd135;
  gbe_pkg::count_t col_pos    = 8'd0;
  gbe_pkg::count_t row_pos    = 8'd0;

  word_item_t word_queue[$];
  pixel_t     expected_pixels[$];

  int   errors = 0;
  int   idle_cycles;
  int   random_words = 0;
  logic in_took;

  int   burst_left;
  int   gap_left;
  bit   drain_hold;
  logic [15:0] stall_pattern;
  int   pattern_age;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Compute the pixels one bitmap word yields and advance the glyph position.
  function automatic void expand_word(gbe_pkg::word_t bits, logic first);
    int     span;
    int     col_next;
    int     row_next;
    bit     fits;
    bit     ends_glyph;
    bit     have_held;
    bit     is_set;
    pixel_t held;
    have_held = 1'b0;
    held = '0;
    if (cur_width == 0 || cur_height == 0) begin
      col_pos = '0;
      row_pos = '0;
      return;
    end
    if (first || col_pos >= cur_width || row_pos >= cur_height) begin
      col_pos = '0;
      row_pos = '0;
    end
    fits = (int'(cur_ox) + int'(cur_width) <= int'(cur_pw)) &&
           (int'(cur_oy) + int'(cur_height) <= int'(cur_ph));
    span = int'(cur_width) - int'(col_pos);
    if (span > gbe_pkg::WORD_BITS) span = gbe_pkg::WORD_BITS;
    ends_glyph = (int'(col_pos) + span == int'(cur_width)) &&
                 (int'(row_pos) + 1 == int'(cur_height));
    if (fits) begin
      for (int i = 0; i < span; i++) begin
        is_set = bits[gbe_pkg::WORD_BITS-1-i];
        if (is_set || !cur_bg[16]) begin
          if (have_held) expected_pixels.push_back(held);
          held.color = is_set ? cur_fg : cur_bg[15:0];
          held.col   = gbe_pkg::coord_t'(int'(cur_ox) + int'(col_pos) + i);
          held.row   = gbe_pkg::coord_t'(int'(cur_oy) + int'(row_pos));
          held.done  = 1'b0;
          held.last  = 1'b0;
          have_held  = 1'b1;
        end
      end
      // flag the final pixel of the word
      if (have_held) begin
        held.done = ends_glyph;
        held.last = 1'b1;
        expected_pixels.push_back(held);
      end
    end
    col_next = int'(col_pos) + span;
    row_next = int'(row_pos);
    if (col_next >= int'(cur_width)) begin
      col_next = 0;
      row_next++;
      if (row_next >= int'(cur_height)) row_next = 0;
    end
    col_pos = gbe_pkg::count_t'(col_next);
    row_pos = gbe_pkg::count_t'(row_next);
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic write_reg(gbe_pkg::cfg_reg_t idx, logic [gbe_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gbe_pkg::CFG_FG_COLOR:     cur_fg     = value[15:0];
      gbe_pkg::CFG_BG_COLOR:     cur_bg     = value[16:0];
      gbe_pkg::CFG_GLYPH_WIDTH:  cur_width  = value[7:0];
      gbe_pkg::CFG_GLYPH_HEIGHT: cur_height = value[7:0];
      gbe_pkg::CFG_ORIGIN_X:     cur_ox     = value[9:0];
      gbe_pkg::CFG_ORIGIN_Y:     cur_oy     = value[9:0];
      gbe_pkg::CFG_PANEL_WIDTH:  cur_pw     = value[9:0];
      gbe_pkg::CFG_PANEL_HEIGHT: cur_ph     = value[9:0];
      default: ;
    endcase
  endtask

  task automatic add_word(gbe_pkg::word_t bits, logic first);
    word_item_t item;
    item.bits  = bits;
    item.first = first;
    word_queue.push_back(item);
  endtask

  // Wait until every word is taken and every pixel has come, then let the pipe empty.
  task automatic settle();
    do @(posedge clk);
    while (word_queue.size() != 0 || word_if.valid || expected_pixels.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(inout int produced);
    int             w, h, pw, ph, ox, oy, n, per_glyph, pos;
    logic [16:0]    bgv;
    logic [15:0]    fgv;
    gbe_pkg::word_t bits;
    logic           first;
    case ($urandom_range(0, 19))
      0:       w = 0;
      1, 2:    w = 255;
      3, 4:    w = 1;
      default: w = $urandom_range(2, 40);
    endcase
    if (w >= 200) h = $urandom_range(1, 2);
    else begin
      case ($urandom_range(0, 19))
        0:       h = 0;
        1:       h = 255;
        2, 3:    h = 1;
        default: h = $urandom_range(2, 6);
      endcase
    end
    case ($urandom_range(0, 9))
      0:       pw = $urandom_range(0, 1);
      1, 2:    pw = 1023;
      default: pw = $urandom_range(256, 1023);
    endcase
    case ($urandom_range(0, 9))
      0:       ph = $urandom_range(0, 1);
      1, 2:    ph = 1023;
      default: ph = $urandom_range(256, 1023);
    endcase
    if ($urandom_range(0, 9) == 0) ox = $urandom_range(0, 1) ? 1023 : $urandom_range(0, 1023);
    else ox = (pw >= w) ? $urandom_range(0, pw - w) : 0;
    if ($urandom_range(0, 9) == 0) oy = $urandom_range(0, 1) ? 1023 : $urandom_range(0, 1023);
    else oy = (ph >= h) ? $urandom_range(0, ph - h) : 0;
    case ($urandom_range(0, 7))
      0, 1:    bgv = 17'h1FFFF;
      2:       bgv = {1'b1, 16'($urandom)};
      3:       bgv = 17'h00000;
      4:       bgv = 17'h0FFFF;
      default: bgv = {1'b0, 16'($urandom)};
    endcase
    case ($urandom_range(0, 7))
      0:       fgv = 16'h0000;
      1:       fgv = 16'hFFFF;
      default: fgv = 16'($urandom);
    endcase

    write_reg(gbe_pkg::CFG_FG_COLOR, {1'b0, fgv});
    write_reg(gbe_pkg::CFG_BG_COLOR, bgv);
    write_reg(gbe_pkg::CFG_GLYPH_WIDTH, 17'(w));
    write_reg(gbe_pkg::CFG_GLYPH_HEIGHT, 17'(h));
    write_reg(gbe_pkg::CFG_ORIGIN_X, 17'(ox));
    write_reg(gbe_pkg::CFG_ORIGIN_Y, 17'(oy));
    write_reg(gbe_pkg::CFG_PANEL_WIDTH, 17'(pw));
    write_reg(gbe_pkg::CFG_PANEL_HEIGHT, 17'(ph));

    n = $urandom_range(10, 40);
    per_glyph = ((w + 15) / 16) * h;
    if (per_glyph == 0) per_glyph = 1;
    // now and then carry on from the previous glyph position
    pos = ($urandom_range(0, 3) == 0) ? 1 : 0;
    for (int k = 0; k < n; k++) begin
      first = (pos % per_glyph == 0);
      if ($urandom_range(0, 19) == 0) first = ~first;
      pos++;
      case ($urandom_range(0, 7))
        0:       bits = '0;
        1:       bits = '1;
        2:       bits = gbe_pkg::word_t'($urandom & $urandom & $urandom);
        default: bits = gbe_pkg::word_t'($urandom);
      endcase
      add_word(bits, first);
    end
    produced += n;
  endtask

  // Word driver: bursts with random gaps, occasionally holding until all pixels are out.
  always @(negedge clk) begin
    if (!rst_n) begin
      word_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      drain_hold = 1'b0;
    end else if (!word_if.valid || in_took) begin
      if (word_if.valid) begin
        word_queue.delete(0);
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        drain_hold = ($urandom_range(0, 11) == 0);
      end
      if (drain_hold && expected_pixels.size() == 0) drain_hold = 1'b0;
      if (gap_left > 0 || drain_hold || word_queue.size() == 0) begin
        word_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        word_if.valid       <= 1'b1;
        word_if.bitmap_word <= word_queue[0].bits;
        word_if.start_glyph <= word_queue[0].first;
      end
    end
  end

  // Pixel receiver: ready follows a rotating pattern that is reloaded now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      pixel_if.ready <= 1'b0;
      pattern_age = 0;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pattern = '1;
          2:       stall_pattern = 16'($urandom);
          3:       stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'h0001;
        endcase
        stall_pattern[0] = 1'b1;
        pattern_age = $urandom_range(8, 64);
      end
      pixel_if.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      pattern_age--;
    end
  end

  always @(posedge clk) begin : monitor
    pixel_t want;
    if (!rst_n) begin
      in_took     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= word_if.valid && word_if.ready;
      if (word_if.valid && word_if.ready)
        expand_word(word_if.bitmap_word, word_if.start_glyph);
      if (pixel_if.valid && pixel_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t ns: pixel with none expected, color %0h column %0d row %0d",
                   $time, pixel_if.pixel_color, pixel_if.pixel_column, pixel_if.pixel_row);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_color", want.color, pixel_if.pixel_color);
          compare_field("pixel_column", 16'(want.col), 16'(pixel_if.pixel_column));
          compare_field("pixel_row", 16'(want.row), 16'(pixel_if.pixel_row));
          compare_field("glyph_done", 16'(want.done), 16'(pixel_if.glyph_done));
          compare_field("last", 16'(want.last), 16'(pixel_if.last));
        end
      end
      if ((word_if.valid && word_if.ready) || (pixel_if.valid && pixel_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = gbe_pkg::CFG_FG_COLOR;
    cfg_data             = '0;
    word_if.valid        = 1'b0;
    word_if.bitmap_word  = '0;
    word_if.start_glyph  = 1'b0;
    pixel_if.ready       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opaque glyph with the reset settings
    add_word(16'h0000, 1'b1);
    add_word(16'hFFFF, 1'b0);
    add_word(16'hA5A5, 1'b0);
    settle();

    // Shrink the glyph mid-stream so the row counter is stale; rows span two words
    write_reg(gbe_pkg::CFG_GLYPH_HEIGHT, 17'd2);
    write_reg(gbe_pkg::CFG_GLYPH_WIDTH, 17'd20);
    write_reg(gbe_pkg::CFG_FG_COLOR, 17'h00000);
    write_reg(gbe_pkg::CFG_BG_COLOR, 17'h0FFFF);
    add_word(16'h8001, 1'b0);
    add_word(16'hFFFF, 1'b0);
    add_word(16'h0F0F, 1'b0);
    add_word(16'h1234, 1'b0);
    settle();

    // Transparent mode; the first glyph ends on a word with no set bits
    write_reg(gbe_pkg::CFG_BG_COLOR, 17'h1FFFF);
    write_reg(gbe_pkg::CFG_GLYPH_WIDTH, 17'd16);
    write_reg(gbe_pkg::CFG_ORIGIN_X, 17'd100);
    write_reg(gbe_pkg::CFG_ORIGIN_Y, 17'd7);
    write_reg(gbe_pkg::CFG_FG_COLOR, 17'h0F81F);
    add_word(16'h8000, 1'b1);
    add_word(16'h0000, 1'b0);
    add_word(16'h0001, 1'b1);
    add_word(16'hFFFF, 1'b0);
    settle();

    // Any negative background is transparent
    write_reg(gbe_pkg::CFG_BG_COLOR, 17'h10000);
    add_word(16'h00FF, 1'b1);
    add_word(16'hF000, 1'b0);
    settle();

    // Off panel to the right, exactly fitting, then off panel at the bottom
    write_reg(gbe_pkg::CFG_ORIGIN_X, 17'd1023);
    add_word(16'hFFFF, 1'b1);
    settle();
    write_reg(gbe_pkg::CFG_ORIGIN_X, 17'd224);
    add_word(16'hFFFF, 1'b1);
    settle();
    write_reg(gbe_pkg::CFG_ORIGIN_X, 17'd0);
    write_reg(gbe_pkg::CFG_ORIGIN_Y, 17'd134);
    add_word(16'hFFFF, 1'b1);
    settle();

    // Zero width, then zero height
    write_reg(gbe_pkg::CFG_ORIGIN_Y, 17'd0);
    write_reg(gbe_pkg::CFG_GLYPH_WIDTH, 17'd0);
    add_word(16'hFFFF, 1'b1);
    add_word(16'hFFFF, 1'b0);
    settle();
    write_reg(gbe_pkg::CFG_GLYPH_WIDTH, 17'd16);
    write_reg(gbe_pkg::CFG_GLYPH_HEIGHT, 17'd0);
    add_word(16'hFFFF, 1'b1);
    settle();

    // One-pixel glyph in the far corner of the largest panel
    write_reg(gbe_pkg::CFG_GLYPH_HEIGHT, 17'd1);
    write_reg(gbe_pkg::CFG_GLYPH_WIDTH, 17'd1);
    write_reg(gbe_pkg::CFG_PANEL_WIDTH, 17'd1023);
    write_reg(gbe_pkg::CFG_PANEL_HEIGHT, 17'd1023);
    write_reg(gbe_pkg::CFG_ORIGIN_X, 17'd1022);
    write_reg(gbe_pkg::CFG_ORIGIN_Y, 17'd1022);
    write_reg(gbe_pkg::CFG_BG_COLOR, 17'h00000);
    add_word(16'h8000, 1'b1);
    add_word(16'h0000, 1'b1);
    settle();

    while (random_words < RANDOM_WORDS) begin
      random_phase(random_words);
      settle();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
